### hw/rtl/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life grid generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int OP_W  = 2;
    localparam int ROW_W = 5;
    localparam int COL_W = 6;
    localparam int GEN_W = 16;
    localparam int CMP_W = 9;   // holds any grid index or size up to 256

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic step;
    } ctl_t;

    typedef struct packed {
        logic             step;
        logic             wr_en;
        logic             wr_val;
        logic [COL_W-1:0] wr_col;
    } row_ctrl_t;

endpackage

### hw/rtl/lgs_row_cell.sv
// ----------------------------------------------------------------------------
// lgs_row_cell
// One grid row: holds COLS cells, takes host writes, and computes their next
// generation from their neighbours in this row and in the rows above and below.
// ----------------------------------------------------------------------------
module lgs_row_cell #(
    parameter int COLS = 35
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lgs_pkg::row_ctrl_t    ctrl,
    input  logic [COLS-1:0]       north,
    input  logic [COLS-1:0]       south,
    output logic [COLS-1:0]       cells
);
    import lgs_pkg::*;

    logic [COLS-1:0] cells_reg;
    logic [COLS-1:0] cells_next;
    logic [COLS+1:0] n_pad;
    logic [COLS+1:0] s_pad;
    logic [COLS+1:0] m_pad;

    assign n_pad = {1'b0, north, 1'b0};
    assign s_pad = {1'b0, south, 1'b0};
    assign m_pad = {1'b0, cells_reg, 1'b0};

    always_comb
    begin
        logic [3:0] cnt;
        cells_next = cells_reg;
        cnt        = '0;
        for (int c = 0; c < COLS; c++)
        begin
            cnt = 4'(n_pad[c]) + 4'(n_pad[c+1]) + 4'(n_pad[c+2])
                + 4'(m_pad[c]) + 4'(m_pad[c+2])
                + 4'(s_pad[c]) + 4'(s_pad[c+1]) + 4'(s_pad[c+2]);
            if (ctrl.step)
            begin
                cells_next[c] = (cnt == 4'd3) || (cells_reg[c] && (cnt == 4'd2));
            end
            else if (ctrl.wr_en && (CMP_W'(ctrl.wr_col) == CMP_W'(c)))
            begin
                cells_next[c] = ctrl.wr_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg <= '0;
        end
        else
        begin
            cells_reg <= cells_next;
        end
    end

    assign cells = cells_reg;

endmodule

### hw/rtl/lgs_ctrl.sv
// ----------------------------------------------------------------------------
// lgs_ctrl
// Handshake, generation counter and result word register.
// ----------------------------------------------------------------------------
module lgs_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lgs_pkg::OP_W-1:0]   op,
    input  logic [lgs_pkg::GEN_W-1:0]  generations,
    input  logic                       addr_cell,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic                       cell_res,
    output logic                       done_res,
    output lgs_pkg::ctl_t              ctl
);
    import lgs_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [GEN_W-1:0] gen_cnt_reg;
    logic [GEN_W-1:0] gen_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             cell_reg;
    logic             cell_next;
    logic             done_reg;
    logic             done_next;
    logic             accept;
    op_t              op_c;

    assign op_c     = op_t'(op);
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next   = state_reg;
        gen_cnt_next = gen_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op_c == OP_ADVANCE) && (generations != '0))
                begin
                    state_next   = ST_RUN;
                    gen_cnt_next = generations;
                end
            end
            ST_RUN:
            begin
                gen_cnt_next = gen_cnt_reg - GEN_W'(1);
                if (gen_cnt_reg == GEN_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctl.wr_en      = 1'b0;
        ctl.step       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        cell_next      = cell_reg;
        done_next      = done_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_c)
                        OP_WRITE:
                        begin
                            ctl.wr_en      = 1'b1;
                            out_valid_next = 1'b1;
                            cell_next      = addr_cell;
                            done_next      = 1'b1;
                        end
                        OP_READ:
                        begin
                            out_valid_next = 1'b1;
                            cell_next      = addr_cell;
                            done_next      = 1'b1;
                        end
                        OP_ADVANCE:
                        begin
                            if (generations == '0)
                            begin
                                out_valid_next = 1'b1;
                                cell_next      = 1'b0;
                                done_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            cell_next      = 1'b0;
                            done_next      = 1'b0;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                ctl.step = 1'b1;
                if (gen_cnt_reg == GEN_W'(1))
                begin
                    out_valid_next = 1'b1;
                    cell_next      = 1'b0;
                    done_next      = 1'b1;
                end
            end
            default:
            begin
                ctl.step = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_cnt_reg   <= gen_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        done_reg <= done_next;
    end

    assign out_valid = out_valid_reg;
    assign cell_res  = cell_reg;
    assign done_res  = done_reg;

endmodule

### hw/rtl/life_grid_generation_step_top.sv
// Results: a write or read word is presented in the cycle after it is accepted.
// An advance of N generations steps every row once per generation, blocking
// input until done, and its result word follows the last one.
// Throughput: one write or read per cycle while the output is not stalled.
// Reset: asynchronous; all cells are cleared to dead at once, no clearing pass.
// ----------------------------------------------------------------------------
// life_grid_generation_step_top
// B3/S23 life grid with host cell write/read and multi-generation advance.
// ----------------------------------------------------------------------------
module life_grid_generation_step_top #(
    parameter int ROWS = 20,
    parameter int COLS = 35
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lgs_pkg::OP_W-1:0]   op,
    input  logic [lgs_pkg::ROW_W-1:0]  row,
    input  logic [lgs_pkg::COL_W-1:0]  col,
    input  logic                       value,
    input  logic [lgs_pkg::GEN_W-1:0]  generations,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       cell_res,
    output logic                       done_res
);
    import lgs_pkg::*;

    ctl_t            ctl;
    logic [COLS-1:0] grid_rows [ROWS];
    logic [COLS-1:0] row_bits;
    logic            cell_bit;
    logic            in_grid;
    logic            addr_cell;

    assign in_grid = (CMP_W'(row) < CMP_W'(ROWS)) && (CMP_W'(col) < CMP_W'(COLS));

    always_comb
    begin
        row_bits = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            if (CMP_W'(row) == CMP_W'(r))
            begin
                row_bits = grid_rows[r];
            end
        end
        cell_bit = 1'b0;
        for (int c = 0; c < COLS; c++)
        begin
            if (CMP_W'(col) == CMP_W'(c))
            begin
                cell_bit = row_bits[c];
            end
        end
    end

    assign addr_cell = (op_t'(op) == OP_WRITE) ? (in_grid && value) : cell_bit;

    lgs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .generations (generations),
        .addr_cell   (addr_cell),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .cell_res    (cell_res),
        .done_res    (done_res),
        .ctl         (ctl)
    );

    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        row_ctrl_t       rc;
        logic [COLS-1:0] north;
        logic [COLS-1:0] south;

        assign rc.step   = ctl.step;
        assign rc.wr_en  = ctl.wr_en && (CMP_W'(row) == CMP_W'(r));
        assign rc.wr_val = value;
        assign rc.wr_col = col;

        if (r == 0)
        begin : g_top
            assign north = '0;
        end
        else
        begin : g_mid_n
            assign north = grid_rows[r-1];
        end

        if (r == ROWS - 1)
        begin : g_bot
            assign south = '0;
        end
        else
        begin : g_mid_s
            assign south = grid_rows[r+1];
        end

        lgs_row_cell #(
            .COLS (COLS)
        ) u_row (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (rc),
            .north (north),
            .south (south),
            .cells (grid_rows[r])
        );
    end

endmodule

### tb/tb_life_grid_generation_step_top.sv
// ----------------------------------------------------------------------------
// tb_life_grid_generation_step_top
// Self-checking bench for the B3/S23 life grid: a short table of directed
// words (grid corners, out-of-range addresses, the unused opcode, zero and
// full-range advances, a blinker and a corner birth), then random write, read
// and advance traffic checked against a bit-parallel model of the grid, under
// three idle/stall mixes on both channels.
// ----------------------------------------------------------------------------
module tb_life_grid_generation_step_top;

    import lgs_pkg::*;

    localparam int ROWS            = 20;
    localparam int COLS            = 35;
    localparam int ITEMS_PER_PHASE = 633;
    localparam int BIG_ADVANCES    = 4;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef logic [COLS-1:0]            row_bits_t;
    typedef logic [ROWS-1:0][COLS-1:0]  grid_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             value;
        logic [GEN_W-1:0] gens;
        bit               typed;
        logic             cell_val;
        logic             done;
    } word_t;

    typedef struct {
        logic cell_val;
        logic done;
    } result_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             value;
    logic [GEN_W-1:0] generations;
    logic             out_valid;
    logic             out_stall;
    logic             cell_res;
    logic             done_res;

    grid_t       life;
    result_t     results_due[$];
    word_t       directed[$];
    int          errors;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hot_r;
    int unsigned hot_c;
    int unsigned big_left;

    life_grid_generation_step_top #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .row         (row),
        .col         (col),
        .value       (value),
        .generations (generations),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cell_res    (cell_res),
        .done_res    (done_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("FAIL life_grid_generation_step_top");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // One generation, eight neighbor vectors summed per row in bit slices.
    function automatic grid_t next_gen(grid_t g);
        grid_t     n;
        row_bits_t up, mid, dn, s0, s1, s2, s3, cy, tmp;
        row_bits_t nb[8];
        int        r, k;
        n = '0;
        for (r = 0; r < ROWS; r++)
        begin
            up  = (r > 0) ? g[r-1] : '0;
            dn  = (r < ROWS - 1) ? g[r+1] : '0;
            mid = g[r];
            nb  = '{up << 1, up, up >> 1, mid << 1, mid >> 1, dn << 1, dn, dn >> 1};
            s0 = '0;
            s1 = '0;
            s2 = '0;
            s3 = '0;
            for (k = 0; k < 8; k++)
            begin
                cy  = s0 & nb[k];
                s0  = s0 ^ nb[k];
                tmp = s1 & cy;
                s1  = s1 ^ cy;
                cy  = tmp;
                tmp = s2 & cy;
                s2  = s2 ^ cy;
                s3  = s3 | tmp;
            end
            n[r] = s1 & ~s2 & ~s3 & (s0 | mid);
        end
        return n;
    endfunction

    // Stops early on a still life or on a grid that flips back to the one before it.
    task automatic advance_life(int unsigned count);
        grid_t       nxt;
        grid_t       prv;
        int unsigned g;
        prv = '0;
        for (g = 0; g < count; g++)
        begin
            nxt = next_gen(life);
            if (nxt == life)
                return;
            if (g > 0 && nxt == prv)
            begin
                if (((count - 1 - g) & 1) == 0)
                    life = nxt;
                return;
            end
            prv  = life;
            life = nxt;
        end
    endtask

    task automatic apply_word(word_t w, output result_t res);
        bit in_grid;
        in_grid      = (w.row < ROWS) && (w.col < COLS);
        res.cell_val = 1'b0;
        res.done     = 1'b1;
        case (w.op)
            OP_WRITE:
                if (in_grid)
                begin
                    life[w.row][w.col] = w.value;
                    res.cell_val       = w.value;
                end
            OP_READ:
                if (in_grid)
                    res.cell_val = life[w.row][w.col];
            OP_ADVANCE:
                advance_life(w.gens);
            default:
                res.done = 1'b0;
        endcase
    endtask

    function automatic word_t mk(logic [OP_W-1:0] o, int r, int c, int v, int g,
                                 int typed, int cell_v, int done);
        word_t w;
        w.op       = o;
        w.row      = ROW_W'(r);
        w.col      = COL_W'(c);
        w.value    = 1'(v);
        w.gens     = GEN_W'(g);
        w.typed    = (typed != 0);
        w.cell_val = 1'(cell_v);
        w.done     = 1'(done);
        return w;
    endfunction

    function automatic word_t rand_word();
        word_t       w;
        int unsigned pick;
        int unsigned area;
        int unsigned span;
        w.typed    = 0;
        w.cell_val = 1'b0;
        w.done     = 1'b0;
        w.row      = ROW_W'($urandom_range(31));
        w.col      = COL_W'($urandom_range(63));
        w.value    = 1'($urandom_range(1));
        w.gens     = GEN_W'($urandom_range(65535));
        area       = $urandom_range(99);
        if (area < 8)
        begin
            case ($urandom_range(2))
                0:       w.row = ROW_W'($urandom_range(31, ROWS));
                1:       w.col = COL_W'($urandom_range(63, COLS));
                default:
                begin
                    w.row = ROW_W'($urandom_range(31, ROWS));
                    w.col = COL_W'($urandom_range(63, COLS));
                end
            endcase
        end
        else if (area < 55)
        begin
            w.row   = ROW_W'(hot_r + $urandom_range(3));
            w.col   = COL_W'(hot_c + $urandom_range(3));
            w.value = ($urandom_range(9) < 6);
        end
        else
        begin
            w.row = ROW_W'($urandom_range(ROWS - 1));
            w.col = COL_W'($urandom_range(COLS - 1));
        end
        pick = $urandom_range(99);
        if (pick < 45)
            w.op = OP_WRITE;
        else if (pick < 78)
            w.op = OP_READ;
        else if (pick < 96)
        begin
            w.op = OP_ADVANCE;
            span = $urandom_range(99);
            if (span < 55)
                w.gens = GEN_W'($urandom_range(3));
            else if (span < 88)
                w.gens = GEN_W'($urandom_range(40, 4));
            else if (span < 98 || big_left == 0)
                w.gens = GEN_W'($urandom_range(300, 41));
            else
                big_left--;
            hot_r = $urandom_range(ROWS - 4);
            hot_c = $urandom_range(COLS - 4);
        end
        else
            w.op = OP_UNUSED;
        return w;
    endfunction

    task automatic send_word(word_t w);
        result_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= w.op;
        row         <= w.row;
        col         <= w.col;
        value       <= w.value;
        generations <= w.gens;
        do
            @(posedge clk);
        while (in_stall);
        apply_word(w, res);
        if (w.typed)
        begin
            res.cell_val = w.cell_val;
            res.done     = w.done;
        end
        results_due.push_back(res);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected word: cell_res=%0b done_res=%0b", cell_res, done_res);
                errors++;
            end
            else
            begin
                e = results_due.pop_front();
                if (cell_res !== e.cell_val)
                begin
                    $error("cell_res expected %0b actual %0b", e.cell_val, cell_res);
                    errors++;
                end
                if (done_res !== e.done)
                begin
                    $error("done_res expected %0b actual %0b", e.done, done_res);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int unsigned pct_send[3];
        int unsigned pct_recv[3];
        int          p;
        int          i;
        int          wait_cycles;
        pct_send      = '{26, 77, 0};
        pct_recv      = '{77, 26, 0};
        errors        = 0;
        life          = '0;
        hot_r         = 8;
        hot_c         = 15;
        big_left      = BIG_ADVANCES;
        send_idle_pct = pct_send[0];
        recv_idle_pct = pct_recv[0];
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_WRITE;
        row           = '0;
        col           = '0;
        value         = 1'b0;
        generations   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed.push_back(mk(OP_READ,     0,  0,  0, 0,      1, 0, 1));
        directed.push_back(mk(OP_READ,     19, 34, 1, 0,      1, 0, 1));
        directed.push_back(mk(OP_WRITE,    0,  0,  1, 0,      1, 1, 1));
        directed.push_back(mk(OP_READ,     0,  0,  0, 0,      1, 1, 1));
        directed.push_back(mk(OP_WRITE,    19, 34, 1, 0,      1, 1, 1));
        directed.push_back(mk(OP_WRITE,    31, 63, 1, 16'hFFFF, 1, 0, 1));
        directed.push_back(mk(OP_READ,     31, 63, 0, 0,      1, 0, 1));
        directed.push_back(mk(OP_WRITE,    20, 0,  1, 0,      1, 0, 1));
        directed.push_back(mk(OP_WRITE,    0,  35, 1, 0,      1, 0, 1));
        directed.push_back(mk(OP_UNUSED,   31, 63, 1, 16'hFFFF, 1, 0, 0));
        directed.push_back(mk(OP_ADVANCE,  0,  0,  0, 0,      1, 0, 1));
        directed.push_back(mk(OP_READ,     19, 34, 0, 0,      1, 1, 1));
        directed.push_back(mk(OP_ADVANCE,  31, 63, 1, 1,      1, 0, 1));
        directed.push_back(mk(OP_READ,     0,  0,  0, 0,      1, 0, 1));
        // blinker, odd full-range advance leaves it vertical
        directed.push_back(mk(OP_WRITE,    5,  10, 1, 0,      1, 1, 1));
        directed.push_back(mk(OP_WRITE,    5,  11, 1, 0,      1, 1, 1));
        directed.push_back(mk(OP_WRITE,    5,  12, 1, 0,      1, 1, 1));
        directed.push_back(mk(OP_ADVANCE,  0,  0,  0, 16'hFFFF, 1, 0, 1));
        directed.push_back(mk(OP_READ,     4,  11, 0, 0,      0, 0, 0));
        directed.push_back(mk(OP_WRITE,    5,  12, 0, 0,      1, 0, 1));
        // corner L, birth completes a block
        directed.push_back(mk(OP_WRITE,    0,  0,  1, 0,      1, 1, 1));
        directed.push_back(mk(OP_WRITE,    0,  1,  1, 0,      1, 1, 1));
        directed.push_back(mk(OP_WRITE,    1,  0,  1, 0,      1, 1, 1));
        directed.push_back(mk(OP_ADVANCE,  0,  0,  0, 3,      1, 0, 1));
        directed.push_back(mk(OP_READ,     1,  1,  0, 0,      0, 0, 0));

        foreach (directed[k])
            send_word(directed[k]);
        drain();

        for (p = 0; p < 3; p++)
        begin
            send_idle_pct = pct_send[p];
            recv_idle_pct = pct_recv[p];
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_word(rand_word());
                if ($urandom_range(149) == 0)
                    drain();
            end
            drain();
        end

        @(negedge clk);
        in_valid    <= 1'b0;
        wait_cycles = 0;
        while (results_due.size() != 0 && wait_cycles < 400000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        if (results_due.size() != 0)
        begin
            $error("%0d result words never arrived", results_due.size());
            errors += results_due.size();
        end
        if (errors == 0)
            $display("PASS life_grid_generation_step_top");
        else
            $display("FAIL life_grid_generation_step_top");
        $finish;
    end

endmodule
